// ===== hw/rtl/tspg_pkg.sv =====
package tspg_pkg;

   localparam int NUM_MOTORS   = 3;
   localparam int PERIOD_WIDTH = 20;
   localparam int COUNT_WIDTH  = 31;
   localparam int CODE_WIDTH   = 4;

   // request item layout
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 72;
   // result item layout
   localparam int RSP_DATA_W = 24;

   // homing presets
   localparam logic [PERIOD_WIDTH-1:0] HOME_PERIOD   = PERIOD_WIDTH'(100);
   localparam logic [COUNT_WIDTH-1:0]  HOME_STEPS_M2 = COUNT_WIDTH'(51200);
   localparam logic [CODE_WIDTH-1:0]   CODE_8        = CODE_WIDTH'(3);
   localparam logic [CODE_WIDTH-1:0]   CODE_16       = CODE_WIDTH'(4);
   localparam logic [CODE_WIDTH-1:0]   CODE_256      = CODE_WIDTH'(8);
   localparam logic [CODE_WIDTH-1:0]   MAX_CODE      = CODE_WIDTH'(8);

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_LOAD = 2'd1,
      OP_HOME = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

endpackage

// ===== hw/rtl/three_axis_step_pulse_generator_top.sv =====
// Three-axis step pulse generator.
// Request channel (req_): one item is a tick of one microsecond, a load of
// one motor (direction, microstep code, step count, step period) or a homing
// start that loads fixed presets into all three motors. The opcode travels
// on req_tuser; the other fields are packed in req_tdata.
// Result channel (rsp_): exactly one item per request, showing the step
// pulses issued by a tick and the motor state after the request: driver
// enables, reverse directions, microstep codes, busy and a refused-load flag.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per clock; the motor state and the result register
// are updated in one pass of per-motor counter and compare logic.
// Stall: the result register holds its item while rsp_tready is low, and
// req_tready drops until that item leaves; it rises again in the cycle the
// result is taken, so a request can enter in the same cycle.
// Reset: all motors stopped, full step, counts, periods and timers zero; no
// result pending.
module three_axis_step_pulse_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] opcode
   input  logic [tspg_pkg::REQ_USER_W-1:0] req_tuser,
   // [1:0] motor, [3:2] direction, [7:4] microstep_code, [38:8] step_count,
   // [58:39] step_period, [62:59] limit_pressed, [67:63] stop_requests
   input  logic [tspg_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] step_pulses, [5:3] driver_enables, [8:6] reverse_dirs,
   // [20:9] microstep_modes, [21] busy_res, [22] load_refused
   output logic [tspg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tspg_pkg::*;

   // unpacked request fields
   opcode_type              opcode;
   logic [1:0]              motor;
   logic [1:0]              direction;
   logic [CODE_WIDTH-1:0]   microstep_code;
   logic [COUNT_WIDTH-1:0]  step_count;
   logic [PERIOD_WIDTH-1:0] step_period;
   logic [3:0]              limit_pressed;
   logic [4:0]              stop_requests;
   logic [5:0]              limit_ext;

   // per-motor state
   logic [1:0]              dir_ff      [NUM_MOTORS];
   logic [1:0]              dir_in      [NUM_MOTORS];
   logic [CODE_WIDTH-1:0]   ustep_ff    [NUM_MOTORS];
   logic [CODE_WIDTH-1:0]   ustep_in    [NUM_MOTORS];
   logic [COUNT_WIDTH-1:0]  remain_ff   [NUM_MOTORS];
   logic [COUNT_WIDTH-1:0]  remain_in   [NUM_MOTORS];
   logic                    cont_ff     [NUM_MOTORS];
   logic                    cont_in     [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] period_ff   [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] period_in   [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] elapsed_ff  [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] elapsed_in  [NUM_MOTORS];
   logic                    run_ff      [NUM_MOTORS];
   logic                    run_in      [NUM_MOTORS];

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_in;

   logic                    req_accept;
   logic [NUM_MOTORS-1:0]   pulses;
   logic [NUM_MOTORS-1:0]   enables;
   logic [NUM_MOTORS-1:0]   revs;
   logic [NUM_MOTORS*CODE_WIDTH-1:0] modes;
   logic                    refused;

   assign opcode         = opcode_type'(req_tuser);
   assign motor          = req_tdata[1:0];
   assign direction      = req_tdata[3:2];
   assign microstep_code = req_tdata[7:4];
   assign step_count     = req_tdata[38:8];
   assign step_period    = req_tdata[58:39];
   assign limit_pressed  = req_tdata[62:59];
   assign stop_requests  = req_tdata[67:63];
   assign limit_ext      = {2'b00, limit_pressed};

   // take a new item whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next motor state and result for the item at the port
   always_comb begin
      logic [PERIOD_WIDTH-1:0] el;
      logic                    blocked;
      el      = '0;
      blocked = 1'b0;
      pulses  = '0;
      refused = 1'b0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         dir_in[m]     = dir_ff[m];
         ustep_in[m]   = ustep_ff[m];
         remain_in[m]  = remain_ff[m];
         cont_in[m]    = cont_ff[m];
         period_in[m]  = period_ff[m];
         elapsed_in[m] = elapsed_ff[m];
         run_in[m]     = run_ff[m];
      end

      case (opcode)
         OP_TICK: begin
            // drop motors 0 and 1 whose stop request matches their direction, motor 2 on bit 4
            for (int m = 0; m < 2; m++) begin
               if ((dir_ff[m] == DIR_FWD && stop_requests[2*m]) ||
                   (dir_ff[m] == DIR_REV && stop_requests[2*m+1])) begin
                  remain_in[m] = '0;
                  run_in[m]    = 1'b0;
                  cont_in[m]   = 1'b0;
               end
            end
            if (stop_requests[4]) begin
               remain_in[2] = '0;
               run_in[2]    = 1'b0;
               cont_in[2]   = 1'b0;
            end
            // advance timers, step at the period
            for (int m = 0; m < NUM_MOTORS; m++) begin
               if (run_in[m]) begin
                  el = elapsed_ff[m] + PERIOD_WIDTH'(1);
                  if (el >= period_ff[m]) begin
                     elapsed_in[m] = '0;
                     if (remain_in[m] != '0) begin
                        pulses[m] = 1'b1;
                        if (!cont_in[m]) begin
                           remain_in[m] = remain_in[m] - COUNT_WIDTH'(1);
                        end
                     end
                     if (remain_in[m] == '0) begin
                        run_in[m]  = 1'b0;
                        cont_in[m] = 1'b0;
                     end
                  end else begin
                     elapsed_in[m] = el;
                  end
               end
            end
         end
         OP_LOAD: begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
               if (motor == 2'(m)) begin
                  if (direction == DIR_FWD || direction == DIR_REV) begin
                     blocked = (m < 2) &&
                               ((direction == DIR_FWD && limit_ext[2*m]) ||
                                (direction == DIR_REV && limit_ext[2*m+1]));
                     if (blocked) begin
                        refused      = 1'b1;
                        remain_in[m] = '0;
                        run_in[m]    = 1'b0;
                        cont_in[m]   = 1'b0;
                     end else begin
                        dir_in[m] = direction;
                        if (microstep_code <= MAX_CODE) begin
                           ustep_in[m] = microstep_code;
                        end
                        period_in[m]  = step_period;
                        elapsed_in[m] = '0;
                        run_in[m]     = 1'b1;
                        if (step_count == '0) begin
                           cont_in[m]   = 1'b1;
                           remain_in[m] = '1;
                        end else begin
                           cont_in[m]   = 1'b0;
                           remain_in[m] = step_count;
                        end
                     end
                  end else begin
                     // stop direction: store settings and halt
                     dir_in[m] = DIR_STOP;
                     if (microstep_code <= MAX_CODE) begin
                        ustep_in[m] = microstep_code;
                     end
                     period_in[m]  = step_period;
                     elapsed_in[m] = '0;
                     remain_in[m]  = '0;
                     run_in[m]     = 1'b0;
                     cont_in[m]    = 1'b0;
                  end
               end
            end
         end
         OP_HOME: begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
               dir_in[m]     = DIR_FWD;
               period_in[m]  = HOME_PERIOD;
               elapsed_in[m] = '0;
               run_in[m]     = 1'b1;
            end
            ustep_in[0]  = CODE_8;
            ustep_in[1]  = CODE_16;
            ustep_in[2]  = CODE_256;
            cont_in[0]   = 1'b1;
            cont_in[1]   = 1'b1;
            cont_in[2]   = 1'b0;
            remain_in[0] = '1;
            remain_in[1] = '1;
            remain_in[2] = HOME_STEPS_M2;
            // hold back motors whose forward switch is pressed
            for (int m = 0; m < 2; m++) begin
               if (limit_ext[2*m]) begin
                  remain_in[m] = '0;
                  run_in[m]    = 1'b0;
                  cont_in[m]   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      // assemble the result from the updated state
      for (int m = 0; m < NUM_MOTORS; m++) begin
         enables[m] = run_in[m];
         revs[m]    = (dir_in[m] == DIR_REV);
         modes[m*CODE_WIDTH +: CODE_WIDTH] = ustep_in[m];
      end
      rsp_data_in = {1'b0, refused, |enables, modes, revs, enables, pulses};
   end

   // result valid: set on accept, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // motor state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            dir_ff[m]     <= DIR_STOP;
            ustep_ff[m]   <= '0;
            remain_ff[m]  <= '0;
            cont_ff[m]    <= 1'b0;
            period_ff[m]  <= '0;
            elapsed_ff[m] <= '0;
            run_ff[m]     <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
               dir_ff[m]     <= dir_in[m];
               ustep_ff[m]   <= ustep_in[m];
               remain_ff[m]  <= remain_in[m];
               cont_ff[m]    <= cont_in[m];
               period_ff[m]  <= period_in[m];
               elapsed_ff[m] <= elapsed_in[m];
               run_ff[m]     <= run_in[m];
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== test/three_axis_step_pulse_generator_top_tb.sv =====
module three_axis_step_pulse_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tspg_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0] DIR_UNUSED = 2'd3;
   localparam logic [1:0] NO_MOTOR   = 2'd3;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = '1;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int QUIET_TAIL    = 150;
   localparam int HOLD_CYCLES   = 240;
   localparam int HOLD_AFTER    = 300;
   localparam int DRAIN_CYCLES  = 4;
   localparam int TIMEOUT_NS    = 1_000_000;

   typedef struct packed {
      logic [1:0]              op;
      logic [1:0]              motor;
      logic [1:0]              dir;
      logic [CODE_WIDTH-1:0]   code;
      logic [COUNT_WIDTH-1:0]  count;
      logic [PERIOD_WIDTH-1:0] period;
      logic [3:0]              limits;
      logic [4:0]              stops;
   } motor_cmd_type;

   typedef struct packed {
      logic [2:0]  pulses;
      logic [2:0]  enables;
      logic [2:0]  revs;
      logic [11:0] modes;
      logic        busy;
      logic        refused;
   } motor_status_type;

   typedef struct packed {
      motor_cmd_type    cmd;
      logic             known;
      motor_status_type want;
   } plan_row_type;

   localparam motor_status_type IDLE_STATUS    = '0;
   localparam motor_status_type REFUSED_STATUS =
      '{3'b000, 3'b000, 3'b000, 12'h000, 1'b0, 1'b1};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   three_axis_step_pulse_generator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // shadow copy of the motor channels
   logic [1:0]              mtr_dir       [NUM_MOTORS];
   logic [CODE_WIDTH-1:0]   mtr_code      [NUM_MOTORS];
   logic [COUNT_WIDTH-1:0]  steps_left    [NUM_MOTORS];
   logic                    free_run      [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] step_interval [NUM_MOTORS];
   logic [PERIOD_WIDTH-1:0] usec_count    [NUM_MOTORS];
   logic                    moving        [NUM_MOTORS];

   motor_status_type pending_status[$];
   motor_status_type seen_status;
   motor_status_type owed_status;

   bit          quiet        = 1'b0;
   bit          held         = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned results_seen  = 0;
   int unsigned pulses_seen   = 0;
   int unsigned refusals_seen = 0;
   int unsigned mismatches    = 0;

   // directed rows; expected status typed in only where it is obvious
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // idle tick right after reset
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b1, IDLE_STATUS},
      // loads into an already pressed switch
      '{'{OP_LOAD, 2'd0, DIR_FWD, 4'd5, 31'd10, 20'd3, 4'b0001, 5'h00}, 1'b1, REFUSED_STATUS},
      '{'{OP_LOAD, 2'd1, DIR_REV, 4'd2, 31'd4, 20'd3, 4'b1000, 5'h00}, 1'b1, REFUSED_STATUS},
      // short move at period zero, other switches pressed
      '{'{OP_LOAD, 2'd0, DIR_FWD, 4'd8, 31'd2, 20'd0, 4'b1110, 5'h00}, 1'b1,
        '{3'b000, 3'b001, 3'b000, 12'h008, 1'b1, 1'b0}},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'b00010}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      // continuous reverse, code out of range
      '{'{OP_LOAD, 2'd1, DIR_REV, 4'd15, 31'd0, 20'd1, 4'b0100, 5'h00}, 1'b0, IDLE_STATUS},
      // direction code three acts as stop
      '{'{OP_LOAD, 2'd2, DIR_UNUSED, 4'd2, COUNT_MAX, PERIOD_MAX, 4'hF, 5'h00}, 1'b0,
        IDLE_STATUS},
      // motor three and opcode three change nothing
      '{'{OP_LOAD, NO_MOTOR, DIR_FWD, 4'd1, 31'd5, 20'd2, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_UNUSED, 2'd1, DIR_FWD, 4'd6, 31'd7, 20'd2, 4'h0, 5'h1F}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'b01000}, 1'b0, IDLE_STATUS},
      // homing with free switches, then stop requests
      '{'{OP_HOME, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'b10000}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'b00001}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'hF, 5'h1F}, 1'b0, IDLE_STATUS},
      // homing with forward switches pressed
      '{'{OP_HOME, 2'd3, DIR_REV, 4'd9, 31'd1, 20'd1, 4'b0101, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_LOAD, 2'd2, DIR_FWD, 4'd0, COUNT_MAX, 20'd0, 4'hF, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_LOAD, 2'd0, DIR_REV, 4'd1, 31'd1, 20'd1, 4'b0001, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_LOAD, 2'd1, DIR_STOP, 4'd7, 31'd3, PERIOD_MAX, 4'h0, 5'h1F}, 1'b0, IDLE_STATUS},
      '{'{OP_LOAD, 2'd2, DIR_STOP, 4'd9, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS},
      '{'{OP_TICK, 2'd0, DIR_STOP, 4'd0, 31'd0, 20'd0, 4'h0, 5'h00}, 1'b0, IDLE_STATUS}
   };

   // stop one motor and drop its count
   function automatic void halt_axis(input int m);
      steps_left[m] = '0;
      moving[m]     = 1'b0;
      free_run[m]   = 1'b0;
   endfunction

   // start one motor; a zero count runs until stopped
   function automatic void arm_axis(input int m, input logic [COUNT_WIDTH-1:0] count,
                                    input logic [PERIOD_WIDTH-1:0] period);
      step_interval[m] = period;
      usec_count[m]    = '0;
      free_run[m]      = (count == '0);
      steps_left[m]    = (count == '0) ? COUNT_MAX : count;
      moving[m]        = 1'b1;
   endfunction

   // only motors 0 and 1 have switches, one per direction
   function automatic bit switch_blocks(input int m, input logic [1:0] d,
                                        input logic [3:0] limits);
      int bit_idx;
      if (m > 1 || !(d == DIR_FWD || d == DIR_REV))
         return 1'b0;
      bit_idx = m * 2 + ((d == DIR_REV) ? 1 : 0);
      return limits[bit_idx];
   endfunction

   // advance the shadow motors by one request and form the status it yields
   function automatic motor_status_type apply_cmd(input motor_cmd_type c);
      motor_status_type s;
      int               mi;
      s  = '0;
      mi = int'(c.motor);
      case (c.op)
         OP_TICK: begin
            // stop requests first, then timing
            for (int m = 0; m < 2; m++) begin
               if (mtr_dir[m] == DIR_FWD && c.stops[2*m])
                  halt_axis(m);
               if (mtr_dir[m] == DIR_REV && c.stops[2*m+1])
                  halt_axis(m);
            end
            if (c.stops[4])
               halt_axis(2);
            for (int m = 0; m < NUM_MOTORS; m++) begin
               if (moving[m]) begin
                  usec_count[m] = usec_count[m] + 1'b1;
                  if (usec_count[m] >= step_interval[m]) begin
                     usec_count[m] = '0;
                     if (steps_left[m] != '0)
                        s.pulses[m] = 1'b1;
                     if (!free_run[m] && steps_left[m] != '0)
                        steps_left[m] = steps_left[m] - 1'b1;
                     if (steps_left[m] == '0)
                        halt_axis(m);
                  end
               end
            end
         end
         OP_LOAD: begin
            if (c.motor != NO_MOTOR) begin
               if (c.dir == DIR_FWD || c.dir == DIR_REV) begin
                  if (switch_blocks(mi, c.dir, c.limits)) begin
                     s.refused = 1'b1;
                     halt_axis(mi);
                  end else begin
                     mtr_dir[mi] = c.dir;
                     if (c.code <= MAX_CODE)
                        mtr_code[mi] = c.code;
                     arm_axis(mi, c.count, c.period);
                  end
               end else begin
                  mtr_dir[mi] = DIR_STOP;
                  if (c.code <= MAX_CODE)
                     mtr_code[mi] = c.code;
                  step_interval[mi] = c.period;
                  usec_count[mi]    = '0;
                  halt_axis(mi);
               end
            end
         end
         OP_HOME: begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
               mtr_dir[m]  = DIR_FWD;
               mtr_code[m] = (m == 0) ? CODE_8 : (m == 1) ? CODE_16 : CODE_256;
               arm_axis(m, (m == 2) ? HOME_STEPS_M2 : '0, HOME_PERIOD);
               if (switch_blocks(m, DIR_FWD, c.limits))
                  halt_axis(m);
            end
         end
         default: begin
         end
      endcase
      for (int m = 0; m < NUM_MOTORS; m++) begin
         s.enables[m]      = moving[m];
         s.revs[m]         = (mtr_dir[m] == DIR_REV);
         s.modes[4*m +: 4] = mtr_code[m];
         s.busy            = s.busy | moving[m];
      end
      return s;
   endfunction

   // mostly ticks and loads with short counts and periods, so motors finish moves
   function automatic motor_cmd_type random_cmd();
      motor_cmd_type c;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 62)
         c.op = OP_TICK;
      else if (pick < 90)
         c.op = OP_LOAD;
      else if (pick < 96)
         c.op = OP_HOME;
      else
         c.op = OP_UNUSED;
      c.motor = ($urandom_range(0, 9) == 0) ? NO_MOTOR : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 40)
         c.dir = DIR_FWD;
      else if (pick < 80)
         c.dir = DIR_REV;
      else if (pick < 92)
         c.dir = DIR_STOP;
      else
         c.dir = DIR_UNUSED;
      c.code = ($urandom_range(0, 4) == 0) ? CODE_WIDTH'($urandom_range(0, 15))
                                           : CODE_WIDTH'($urandom_range(0, 8));
      pick = $urandom_range(0, 7);
      if (pick == 0)
         c.count = COUNT_WIDTH'($urandom);
      else if (pick == 1)
         c.count = '0;
      else
         c.count = COUNT_WIDTH'($urandom_range(1, 12));
      c.period = ($urandom_range(0, 7) == 0) ? PERIOD_WIDTH'($urandom)
                                             : PERIOD_WIDTH'($urandom_range(0, 6));
      c.limits = ($urandom_range(0, 1) == 0) ? 4'($urandom) : 4'h0;
      c.stops  = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'h00;
      return c;
   endfunction

   // offer one item, wait for the handshake, then record what it should produce
   task automatic offer_cmd(input motor_cmd_type c, input logic known,
                            input motor_status_type want);
      motor_status_type predicted;
      int unsigned      gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {4'b0, c.stops, c.limits, c.period, c.count, c.code, c.dir, c.motor};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_cmd(c);
      pending_status.push_back(known ? want : predicted);
      requests_sent++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // stimulus
   initial begin
      motor_cmd_type c;
      int unsigned   useful;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         mtr_dir[m]       = DIR_STOP;
         mtr_code[m]      = '0;
         steps_left[m]    = '0;
         free_run[m]      = 1'b0;
         step_interval[m] = '0;
         usec_count[m]    = '0;
         moving[m]        = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_cmd(directed_plan[i].cmd, directed_plan[i].known, directed_plan[i].want);

      // ignored items do not count toward the random total
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         c     = random_cmd();
         quiet = (useful + QUIET_TAIL >= RANDOM_ITEMS);
         offer_cmd(c, 1'b0, IDLE_STATUS);
         if (!(c.op == OP_UNUSED || (c.op == OP_LOAD && c.motor == NO_MOTOR)))
            useful++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding results
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d directed) and checked %0d status items.",
               requests_sent, DIRECTED_ROWS, results_seen);
      $display("Saw %0d step pulses and %0d refused loads; output held off for %0d cycles.",
               pulses_seen, refusals_seen, HOLD_CYCLES);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // output backpressure: random stalls, one long hold-off, none near the end
   initial begin
      forever begin
         if (!quiet && !held && requests_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // compare each accepted status item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_status.pulses  = rsp_tdata[2:0];
         seen_status.enables = rsp_tdata[5:3];
         seen_status.revs    = rsp_tdata[8:6];
         seen_status.modes   = rsp_tdata[20:9];
         seen_status.busy    = rsp_tdata[21];
         seen_status.refused = rsp_tdata[22];
         results_seen++;
         pulses_seen   += $countones(seen_status.pulses);
         refusals_seen += seen_status.refused;
         if (pending_status.size() == 0) begin
            $error("status item 0x%0h arrived with no request outstanding", rsp_tdata);
            mismatches++;
         end else begin
            owed_status = pending_status.pop_front();
            check_field("step_pulses", owed_status.pulses, seen_status.pulses);
            check_field("driver_enables", owed_status.enables, seen_status.enables);
            check_field("reverse_dirs", owed_status.revs, seen_status.revs);
            check_field("microstep_modes", owed_status.modes, seen_status.modes);
            check_field("busy_res", owed_status.busy, seen_status.busy);
            check_field("load_refused", owed_status.refused, seen_status.refused);
         end
      end
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
